// ===== src/asrs_pkg.sv =====
`timescale 1ns / 1ps

package asrs_pkg;

    localparam int unsigned REGISTER_COUNT = 32;
    localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int unsigned WINDOW_LEN = 5;

    localparam logic [7:0] CODE_WRITE        = 8'h00;
    localparam logic [7:0] CODE_READ         = 8'h01;
    localparam logic [7:0] END_MARK          = 8'hFF;
    localparam logic [7:0] BROADCAST_ADDRESS = 8'h02;
    localparam logic [7:0] ADDRESS_AT_RESET  = 8'hAA;
    localparam logic [8:0] INDEX_LIMIT       = 9'(REGISTER_COUNT);

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } asrs_wr_t;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } asrs_rd_t;

endpackage

// ===== src/asrs_regfile.sv =====
`timescale 1ns / 1ps

module asrs_regfile (
    input  logic             aclk,
    input  logic             aresetn,
    input  asrs_pkg::asrs_wr_t wr,
    input  asrs_pkg::asrs_rd_t rd,
    output logic [7:0]       rd_data
);

    logic [7:0] store_reg [asrs_pkg::REGISTER_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(asrs_pkg::REGISTER_COUNT); i++) begin
                store_reg[i] <= 8'h00;
            end
        end else if (wr.en) begin
            store_reg[wr.idx] <= wr.data;
        end
    end

    // out of range index reads as zero
    assign rd_data = rd.in_range ? store_reg[rd.idx] : 8'h00;

endmodule

// ===== src/addressed_serial_register_slave.sv =====
`timescale 1ns / 1ps

// Addressed serial register slave. Each accepted byte enters a five-byte window; when the
// newest byte is 0xFF and the oldest is the write code 0x00 or read code 0x01, the window is a
// packet laid out as code, register index, address, data, end mark. Packets addressed to
// device_address (reset 0xAA) or the broadcast address 0x02 act on a 32-entry register store
// that reset clears: a write stores the data byte, a read returns the stored byte as one
// transaction on the m_axis side. Indexes at or beyond 32 are ignored on write and read as 0.
// The block takes one byte per cycle unless input is held off. A byte is decoded in the cycle
// after it is accepted, between the window register and the reply register, so an end mark
// passes both registers before its reply is valid. Input is held off only when a read reply
// is ready while the previous reply still waits on m_axis_tready. device_address is to be written
// by the user via cfg_wr_en and cfg_wr_data only while the block is idle; the block does not enforce it.
module addressed_serial_register_slave (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] reply_byte
);

    logic [7:0] dev_addr_reg;
    logic [7:0] win_reg [asrs_pkg::WINDOW_LEN];
    logic       item_valid_reg;
    logic       item_valid_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_data_reg;
    logic [7:0] m_data_next;

    logic       s_accept;
    logic       addressed;
    logic       packet_hit;
    logic       read_hit;
    logic       write_hit;
    logic       in_range;
    logic       stall;
    logic       reply_load;
    logic [7:0] rd_data;

    asrs_pkg::asrs_wr_t wr;
    asrs_pkg::asrs_rd_t rd;

    // window: [0] code, [1] index, [2] address, [3] data, [4] newest
    assign addressed  = (win_reg[2] == dev_addr_reg) ||
                        (win_reg[2] == asrs_pkg::BROADCAST_ADDRESS);
    assign packet_hit = item_valid_reg && (win_reg[4] == asrs_pkg::END_MARK) && addressed;
    assign read_hit   = packet_hit && (win_reg[0] == asrs_pkg::CODE_READ);
    assign write_hit  = packet_hit && (win_reg[0] == asrs_pkg::CODE_WRITE);
    assign in_range   = {1'b0, win_reg[1]} < asrs_pkg::INDEX_LIMIT;

    assign stall      = read_hit && m_valid_reg && !m_axis_tready;
    assign reply_load = read_hit && !stall;

    assign s_axis_tready = !stall;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign wr.en   = write_hit && in_range;
    assign wr.idx  = win_reg[1][asrs_pkg::IDX_W-1:0];
    assign wr.data = win_reg[3];

    assign rd.in_range = in_range;
    assign rd.idx      = win_reg[1][asrs_pkg::IDX_W-1:0];

    asrs_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    always_comb begin
        item_valid_next = s_accept ? 1'b1 : stall;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        if (reply_load) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_data;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= asrs_pkg::ADDRESS_AT_RESET;
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < int'(asrs_pkg::WINDOW_LEN); i++) begin
                win_reg[i] <= 8'h00;
            end
        end else begin
            if (cfg_wr_en) begin
                dev_addr_reg <= cfg_wr_data;
            end
            item_valid_reg <= item_valid_next;
            m_valid_reg    <= m_valid_next;
            if (s_accept) begin
                for (int i = 0; i < int'(asrs_pkg::WINDOW_LEN) - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[asrs_pkg::WINDOW_LEN-1] <= s_axis_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a read that is not held back always shows up as a reply
    a_read_gives_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_load |=> m_axis_tvalid)
        else $error("read packet did not produce a reply");

    // a store write and a reply load never come from the same packet
    a_write_read_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.en && reply_load))
        else $error("store write and reply load at once");

    // a byte that is not an end mark never creates a reply
    a_no_reply_without_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && (win_reg[4] != asrs_pkg::END_MARK) &&
         !(m_valid_reg && !m_axis_tready)) |=> !m_axis_tvalid)
        else $error("reply without end mark");

endmodule
